@@ rtl/kcfb_pkg.sv @@
// shared types, cipher tables and linear-layer functions for the kuznyechik cfb block
// no dependencies
package kcfb_pkg;

   localparam int ROUNDS     = 10;
   localparam int KEY_STEPS  = 32;
   localparam int RAM_AW     = 4;
   localparam int CSR_IW     = 3;

   // register indexes of the configuration port
   localparam logic [CSR_IW-1:0] CSR_KEY0 = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_KEY1 = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_KEY2 = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_KEY3 = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_DIR  = 3'd4;

   typedef struct packed {
      logic        first_block;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   // write port of the round key memory
   typedef struct packed {
      logic              en;
      logic [RAM_AW-1:0] addr;
      logic [127:0]      data;
   } kcfb_wr_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
      8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
      8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
      8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
      8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
      8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
      8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
      8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
      8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
      8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
      8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
      8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
      8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
      8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
      8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
      8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
   };

   localparam logic [7:0] LCOEF [16] = '{
      8'h94,8'h20,8'h85,8'h10,8'hC2,8'hC0,8'h01,8'hFB,
      8'h01,8'hC0,8'hC2,8'h10,8'h85,8'h20,8'h94,8'h01
   };

   // multiply in gf(2^8) modulo x^8 + x^7 + x^6 + x + 1
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] x;
      r = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            r = r ^ x;
         end
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'hC3 : 8'h00);
      end
      return r;
   endfunction

   // sixteen lfsr steps, used only to build constant tables
   function automatic logic [127:0] lin_slow(input logic [127:0] v);
      logic [127:0] d;
      logic [7:0]   t;
      d = v;
      for (int r = 0; r < 16; r++) begin
         t = 8'h00;
         for (int j = 0; j < 16; j++) begin
            t = t ^ gf_mul(d[8*j +: 8], LCOEF[j]);
         end
         d = {d[119:0], t};
      end
      return d;
   endfunction

   // matrix of the linear layer, entry (i, j) at bits (i*16+j)*8
   function automatic logic [2047:0] lmat_calc();
      logic [2047:0] m;
      logic [127:0]  col;
      m = '0;
      for (int j = 0; j < 16; j++) begin
         col = lin_slow(128'(1) << (8 * j));
         for (int i = 0; i < 16; i++) begin
            m[(i*16+j)*8 +: 8] = col[8*i +: 8];
         end
      end
      return m;
   endfunction

   localparam logic [2047:0] LMAT = lmat_calc();

   // iteration constants of the key schedule, step s at bits s*128
   function automatic logic [KEY_STEPS*128-1:0] kc_calc();
      logic [KEY_STEPS*128-1:0] c;
      c = '0;
      for (int s = 0; s < KEY_STEPS; s++) begin
         c[s*128 +: 128] = lin_slow(128'(s + 1) << 120);
      end
      return c;
   endfunction

   localparam logic [KEY_STEPS*128-1:0] KEY_CONST = kc_calc();

   function automatic logic [127:0] sub_bytes(input logic [127:0] v);
      logic [127:0] d;
      for (int j = 0; j < 16; j++) begin
         d[8*j +: 8] = SBOX[v[8*j +: 8]];
      end
      return d;
   endfunction

   // linear layer as one constant matrix product
   function automatic logic [127:0] lin_fast(input logic [127:0] v);
      logic [127:0] d;
      logic [7:0]   acc;
      for (int i = 0; i < 16; i++) begin
         acc = 8'h00;
         for (int j = 0; j < 16; j++) begin
            acc = acc ^ gf_mul(v[8*j +: 8], LMAT[(i*16+j)*8 +: 8]);
         end
         d[8*i +: 8] = acc;
      end
      return d;
   endfunction

endpackage

@@ rtl/kcfb_round.sv @@
// shared round unit: byte substitution followed by the linear layer
// depends on kcfb_pkg
module kcfb_round (
   input  logic [127:0] x,
   output logic [127:0] y
);
   import kcfb_pkg::*;

   assign y = lin_fast(sub_bytes(x));

endmodule

@@ rtl/kcfb_key_ram.sv @@
// round key memory, one write port and one registered read port
// depends on kcfb_pkg
module kcfb_key_ram (
   input  logic                          clock,
   input  kcfb_pkg::kcfb_wr_type         wr,
   input  logic [kcfb_pkg::RAM_AW-1:0]   raddr,
   output logic [127:0]                  rdata_ff
);
   import kcfb_pkg::*;

   logic [127:0] mem [ROUNDS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

@@ rtl/kuznyechik_cfb_cipher.sv @@
// kuznyechik cipher feedback top level: control sequencer, feedback and output register
// depends on kcfb_pkg, kcfb_round, kcfb_key_ram
// sequencing: a continuing block runs its rounds through the shared round unit, the ten round
//   keys streamed from the key memory; a first block first runs the 32-step key schedule and
//   the tail write, the schedule through the same unit
// a new block is accepted only while the sequencer is idle, once the previous result has
//   been loaded into the output register
// reset: synchronous active high, clears sequencer, feedback block, key and direction
//   registers; the key memory has no reset and is filled by the first block of a message
module kuznyechik_cfb_cipher (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  kcfb_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output kcfb_pkg::rsp_type            rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [kcfb_pkg::CSR_IW-1:0]  csr_index,
   input  logic [63:0]                  csr_data
);
   import kcfb_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_KEY  = 2'd1;
   localparam logic [1:0] ST_TAIL = 2'd2;
   localparam logic [1:0] ST_ENC  = 2'd3;

   localparam logic [3:0] LAST_ROUND = 4'(ROUNDS - 1);
   localparam logic [4:0] LAST_STEP  = 5'(KEY_STEPS - 1);

   logic [1:0]   state_ff, state_in;
   logic [3:0]   round_ff, round_in;
   logic [4:0]   step_ff, step_in;
   logic [63:0]  key_ff [4];
   logic         dir_ff;
   logic [127:0] fb_ff, fb_in;
   logic [127:0] data_ff, data_in;     // cipher state through the rounds
   logic [127:0] ka_ff, ka_in;         // feistel halves of the key schedule
   logic [127:0] kb_ff, kb_in;
   logic [127:0] blk_ff, blk_in;       // captured input block
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff, rsp_data_in;

   logic [127:0] round_x, round_y, rkey, feistel_t, result;
   logic [RAM_AW-1:0] raddr;
   kcfb_wr_type  wr;
   logic         req_fire, rsp_load;

   kcfb_round u_round (
      .x (round_x),
      .y (round_y)
   );

   kcfb_key_ram u_ram (
      .clock    (clock),
      .wr       (wr),
      .raddr    (raddr),
      .rdata_ff (rkey)
   );

   // configuration is taken at any time; the user writes only while idle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            key_ff[i] <= '0;
         end
         dir_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY0: key_ff[0] <= csr_data;
            CSR_KEY1: key_ff[1] <= csr_data;
            CSR_KEY2: key_ff[2] <= csr_data;
            CSR_KEY3: key_ff[3] <= csr_data;
            CSR_DIR:  dir_ff    <= csr_data[0];
            default:  ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // one feistel step of the key schedule or one cipher round shares the round unit
   assign round_x   = (state_ff == ST_KEY) ? (ka_ff ^ KEY_CONST[step_ff*128 +: 128])
                                           : (data_ff ^ rkey);
   assign feistel_t = round_y ^ kb_ff;
   assign result    = data_ff ^ rkey ^ blk_ff;

   // final round result leaves once the output register is free
   assign rsp_load  = (state_ff == ST_ENC) && (round_ff == LAST_ROUND) &&
                      (!rsp_valid_ff || rsp_ready);

   // key memory read address runs one round ahead; row 0 is kept ready while idle
   always_comb begin
      raddr = '0;
      if (state_ff == ST_ENC) begin
         raddr = (round_ff == LAST_ROUND) ? LAST_ROUND : RAM_AW'(round_ff + 4'd1);
      end
   end

   // key memory writes: the two key halves at the first two steps, then each new pair
   // as it forms, the second half of a pair one step later from kb_ff, the last in the tail
   always_comb begin
      wr.en   = 1'b0;
      wr.addr = '0;
      wr.data = '0;
      if (state_ff == ST_KEY) begin
         if (step_ff == 5'd0) begin
            wr.en   = 1'b1;
            wr.data = {key_ff[1], key_ff[0]};
         end else if (step_ff == 5'd1) begin
            wr.en   = 1'b1;
            wr.addr = RAM_AW'(1);
            wr.data = {key_ff[3], key_ff[2]};
         end else if (step_ff[2:0] == 3'd7) begin
            wr.en   = 1'b1;
            wr.addr = RAM_AW'({step_ff[4:3], 1'b0} + 3'd2);
            wr.data = feistel_t;
         end else if (step_ff[2:0] == 3'd0) begin
            wr.en   = 1'b1;
            wr.addr = RAM_AW'({step_ff[4:3], 1'b1});
            wr.data = kb_ff;
         end
      end else if (state_ff == ST_TAIL) begin
         wr.en   = 1'b1;
         wr.addr = LAST_ROUND;
         wr.data = kb_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      step_in      = step_ff;
      fb_in        = fb_ff;
      data_in      = data_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      blk_in       = blk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               blk_in   = {req_data.block_high, req_data.block_low};
               round_in = '0;
               if (req_data.first_block) begin
                  // new message: iv is the first key half
                  data_in  = {key_ff[1], key_ff[0]};
                  ka_in    = {key_ff[1], key_ff[0]};
                  kb_in    = {key_ff[3], key_ff[2]};
                  step_in  = '0;
                  state_in = ST_KEY;
               end else begin
                  data_in  = fb_ff;
                  state_in = ST_ENC;
               end
            end
         end
         ST_KEY: begin
            ka_in   = feistel_t;
            kb_in   = ka_ff;
            step_in = step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_ENC;
         end
         ST_ENC: begin
            if (round_ff != LAST_ROUND) begin
               data_in  = round_y;
               round_in = round_ff + 4'd1;
            end else if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {result[127:64], result[63:0]};
               // ciphertext feeds back: the input when decrypting, the result otherwise
               fb_in        = dir_ff ? blk_ff : result;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         step_ff      <= '0;
         fb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         step_ff      <= step_in;
         fb_ff        <= fb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      ka_ff       <= ka_in;
      kb_ff       <= kb_in;
      blk_ff      <= blk_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result overwritten");

   // the key memory is not written while rounds read it
   a_no_write_in_enc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ENC) || (state_ff == ST_IDLE) |-> !wr.en)
      else $error("key memory written outside key schedule");

   // the schedule always hands over to the rounds through the tail write
   a_tail_to_enc: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TAIL |=> state_ff == ST_ENC && round_ff == 4'd0)
      else $error("tail cycle did not start the rounds");

   // a result appears only after the last round
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_ENC && $past(round_ff) == LAST_ROUND)
      else $error("result raised outside the last round");

endmodule

@@ dv/tb_kuznyechik_cfb_cipher.sv @@
// self-checking testbench for the kuznyechik cfb cipher block
// depends on kcfb_pkg and kuznyechik_cfb_cipher; predicts every result with its own cipher
`timescale 1ns / 100ps

module tb_kuznyechik_cfb_cipher;
   import kcfb_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   // indexes above the direction register decode to nothing
   localparam logic [CSR_IW-1:0] CSR_FIRST_UNUSED = CSR_DIR + 3'd1;
   localparam logic [CSR_IW-1:0] CSR_LAST_UNUSED  = '1;

   localparam logic [7:0] PI_TABLE [256] = '{
      8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
      8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
      8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
      8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
      8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
      8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
      8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
      8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
      8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
      8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
      8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
      8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
      8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
      8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
      8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
      8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
   };

   // lfsr tap weights, byte 0 of the vector first
   localparam logic [7:0] TAP_WEIGHT [16] = '{
      8'h94,8'h20,8'h85,8'h10,8'hC2,8'hC0,8'h01,8'hFB,
      8'h01,8'hC0,8'hC2,8'h10,8'h85,8'h20,8'h94,8'h01
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   // shadow of the block: key registers, direction, round keys, feedback chain
   logic [63:0]  shadow_key [4];
   logic         shadow_decrypt;
   logic [127:0] shadow_round_key [ROUNDS];
   logic [127:0] shadow_feedback;

   req_type      blocks_to_send [$];
   rsp_type      expected_ciphertext [$];
   int           accepted_blocks = 0;
   int           error_count = 0;
   int           idle_cycles = 0;
   int           sender_idle_pct = 0;
   int           receiver_stall_pct = 0;

   kuznyechik_cfb_cipher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- cipher predictor

   // product in gf(2^8), field polynomial x^8 + x^7 + x^6 + x + 1
   function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x;
         end
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'hC3 : 8'h00);
      end
      return acc;
   endfunction

   // linear diffusion: sixteen shifts of the byte lfsr, new byte enters at byte 0
   function automatic logic [127:0] diffuse(input logic [127:0] v);
      logic [127:0] d;
      logic [7:0]   fb;
      d = v;
      for (int r = 0; r < 16; r++) begin
         fb = 8'h00;
         for (int j = 0; j < 16; j++) begin
            fb = fb ^ gf_times(d[8*j +: 8], TAP_WEIGHT[j]);
         end
         d = {d[119:0], fb};
      end
      return d;
   endfunction

   // one substitution then diffusion
   function automatic logic [127:0] mix_round(input logic [127:0] v);
      logic [127:0] s;
      for (int j = 0; j < 16; j++) begin
         s[8*j +: 8] = PI_TABLE[v[8*j +: 8]];
      end
      return diffuse(s);
   endfunction

   // feistel key schedule, 32 steps, constant n placed in byte 15
   task automatic schedule_round_keys();
      logic [127:0] left;
      logic [127:0] right;
      logic [127:0] step_out;
      logic [127:0] step_const;
      left  = {shadow_key[1], shadow_key[0]};
      right = {shadow_key[3], shadow_key[2]};
      shadow_round_key[0] = left;
      shadow_round_key[1] = right;
      for (int i = 1; i < ROUNDS / 2; i++) begin
         for (int j = 0; j < 8; j++) begin
            step_const = diffuse(128'(8 * (i - 1) + j + 1) << 120);
            step_out   = mix_round(left ^ step_const) ^ right;
            right      = left;
            left       = step_out;
         end
         shadow_round_key[2*i]   = left;
         shadow_round_key[2*i+1] = right;
      end
   endtask

   function automatic logic [127:0] encrypt_feedback(input logic [127:0] v);
      logic [127:0] d;
      d = v;
      for (int r = 0; r < ROUNDS; r++) begin
         d = d ^ shadow_round_key[r];
         if (r < ROUNDS - 1) begin
            d = mix_round(d);
         end
      end
      return d;
   endfunction

   // advance the shadow chain by one accepted block and queue its ciphertext
   task automatic predict_block(input req_type blk);
      logic [127:0] data_in;
      logic [127:0] data_out;
      if (blk.first_block) begin
         schedule_round_keys();
         shadow_feedback = {shadow_key[1], shadow_key[0]};
      end
      data_in  = {blk.block_high, blk.block_low};
      data_out = encrypt_feedback(shadow_feedback) ^ data_in;
      expected_ciphertext.push_back(data_out);
      shadow_feedback = shadow_decrypt ? data_in : data_out;
   endtask

   // ---------------------------------------------------------------- drivers and checker

   // request side: hold a pending transaction until accepted, otherwise maybe idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_block(blocks_to_send.pop_front());
            accepted_blocks++;
         end
         if (req_valid && !req_ready) begin
            // payload held until the transaction completes
         end else if (blocks_to_send.size() > 0 &&
                      $urandom_range(99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= blocks_to_send[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // compare every response transaction with the oldest prediction
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_ciphertext.size() == 0) begin
            $error("response with no block outstanding: %h", rsp_data);
            error_count++;
         end else begin
            exp_rsp = expected_ciphertext.pop_front();
            if (rsp_data.result_low !== exp_rsp.result_low) begin
               $error("result_low expected %h actual %h", exp_rsp.result_low,
                      rsp_data.result_low);
               error_count++;
            end
            if (rsp_data.result_high !== exp_rsp.result_high) begin
               $error("result_high expected %h actual %h", exp_rsp.result_high,
                      rsp_data.result_high);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- shared tasks

   task automatic send_block(input logic first, input logic [63:0] lo, input logic [63:0] hi);
      req_type blk;
      blk.first_block = first;
      blk.block_low   = lo;
      blk.block_high  = hi;
      wait (blocks_to_send.size() < 2);
      blocks_to_send.push_back(blk);
   endtask

   // block fully idle: nothing queued, nothing in flight, nothing outstanding
   task automatic wait_idle();
      wait (blocks_to_send.size() == 0 && expected_ciphertext.size() == 0);
      @(posedge clock);
      wait (!req_valid && expected_ciphertext.size() == 0);
      repeat (4) @(posedge clock);
   endtask

   // write every register back to back, spare indexes too; only while idle
   task automatic write_registers(input logic [63:0] k0, input logic [63:0] k1,
                                  input logic [63:0] k2, input logic [63:0] k3,
                                  input logic dir);
      logic [63:0] values [5];
      logic [CSR_IW-1:0] idx;
      values = '{k0, k1, k2, k3, 64'(0)};
      values[4] = {$urandom, 31'($urandom), dir};
      @(posedge clock);
      for (int i = 0; i < 5; i++) begin
         idx = CSR_KEY0 + CSR_IW'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= values[i];
         do @(posedge clock); while (!csr_ready);
         if (idx == CSR_DIR) begin
            shadow_decrypt = values[i][0];
         end else begin
            shadow_key[i] = values[i];
         end
      end
      // spare indexes must leave every register alone
      for (int u = int'(CSR_FIRST_UNUSED); u <= int'(CSR_LAST_UNUSED); u++) begin
         csr_index <= CSR_IW'(u);
         csr_data  <= {$urandom, $urandom};
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [63:0] rand_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // one message: a first block, then more blocks, each a new first block one time in 30
   task automatic send_message(input int length);
      for (int i = 0; i < length; i++) begin
         send_block(i == 0 || $urandom_range(29) == 0, rand_word(), rand_word());
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      // reset key of all zeros, encrypt
      send_block(1'b1, '0, '0);
      send_block(1'b0, '1, '1);
      send_block(1'b0, 64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
      wait_idle();
      // all-ones key, decrypt, back-to-back first blocks
      write_registers('1, '1, '1, '1, 1'b1);
      send_block(1'b1, '0, '1);
      send_block(1'b1, '1, '0);
      send_block(1'b0, 64'h8000000000000001, 64'h8000000000000001);
      wait_idle();
      // direction flips inside a message, chain carries on
      write_registers('1, '1, '1, '1, 1'b0);
      send_block(1'b0, 64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA);
      send_block(1'b0, '0, '0);
      wait_idle();
      // new key mid message: only picked up by the next first block
      write_registers(64'h0011223344556677, 64'h8899AABBCCDDEEFF,
                      64'hFEDCBA9876543210, 64'h0123456789ABCDEF, 1'b1);
      send_block(1'b0, 64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555);
      send_block(1'b1, '1, '1);
      send_block(1'b0, '0, '0);
      send_block(1'b0, 64'h0000000100000001, 64'hF0F0F0F00F0F0F0F);
      wait_idle();
   endtask

   task automatic test_random_phase(input int idle_pct, input int stall_pct, input int items,
                                    input logic with_pause);
      int sent;
      int len;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < items) begin
         if (sent % 60 == 0) begin
            wait_idle();
            write_registers(rand_word(), rand_word(), rand_word(), rand_word(),
                            1'($urandom));
         end
         len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
         send_message(len);
         sent += len;
         // with pauses on, the sender sometimes holds off until the block has drained
         if (with_pause && $urandom_range(3) == 0) begin
            wait_idle();
         end
      end
      wait_idle();
   endtask

   initial begin
      shadow_key      = '{default: '0};
      shadow_decrypt  = 1'b0;
      shadow_feedback = '0;
      shadow_round_key = '{default: '0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phase(0, 0, 175, 1'b1);
      test_random_phase(83, 0, 175, 1'b0);
      test_random_phase(0, 83, 175, 1'b0);
      test_random_phase(10, 10, 175, 1'b1);
      wait_idle();
      repeat (50) @(posedge clock);
      if (error_count == 0 && expected_ciphertext.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
